>>> rtl/phsv_pkg.sv
package phsv_pkg;

  // Field widths.
  localparam int unsigned CH_W   = 8;   // one color channel
  localparam int unsigned NUM_W  = 17;  // divider numerator and remainder
  localparam int unsigned DEN_W  = 9;   // divider denominator
  localparam int unsigned QUO_W  = 8;   // divider quotient
  localparam int unsigned HUE_W  = 9;   // hue 0..359
  localparam int unsigned FRAC_W = 6;   // position inside a sextant, 0..59

  // Channel and HSV constants.
  localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;
  localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
  localparam logic [HUE_W-1:0] HUE_SEXT  = 9'd60;
  localparam logic [16:0]      S_SCALE   = 17'd510;
  localparam logic [16:0]      H_SCALE   = 17'd120;
  localparam logic [13:0]      PQ_HALF   = 14'd15300;

  // Constant divisions of the back conversion as reciprocal multiplies.
  // A numerator below 2**N divided by D is exact with
  // M = ceil(2**(N + ceil(log2 D)) / D) and a right shift by N + ceil(log2 D).
  localparam int unsigned NP_W    = 17;
  localparam int unsigned DIV_P   = 510;
  localparam int unsigned SHIFT_P = 26;
  localparam int unsigned RCP_P_W = 18;
  localparam logic [RCP_P_W-1:0] RECIP_P =
    RCP_P_W'(((64'd1 << SHIFT_P) + 64'(DIV_P) - 64'd1) / 64'(DIV_P));

  localparam int unsigned NQ_W    = 23;
  localparam int unsigned DIV_Q   = 30600;
  localparam int unsigned SHIFT_Q = 38;
  localparam int unsigned RCP_Q_W = 24;
  localparam logic [RCP_Q_W-1:0] RECIP_Q =
    RCP_Q_W'(((64'd1 << SHIFT_Q) + 64'(DIV_Q) - 64'd1) / 64'(DIV_Q));

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_HUE = 2'd0,
    REG_SAT = 2'd1,
    REG_VAL = 2'd2
  } cfg_reg_e;

  // Channel holding the maximum.
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_chan_e;

  // Hue sextant.
  typedef enum logic [2:0] {
    SEXT_0 = 3'd0,
    SEXT_1 = 3'd1,
    SEXT_2 = 3'd2,
    SEXT_3 = 3'd3,
    SEXT_4 = 3'd4,
    SEXT_5 = 3'd5
  } sextant_e;

  // Operands of the two divisions done side by side.
  typedef struct packed {
    logic [NUM_W-1:0] num_s;
    logic [DEN_W-1:0] den_s;
    logic [NUM_W-1:0] num_h;
    logic [DEN_W-1:0] den_h;
  } div_op_t;

  // Pixel data that rides along the divider.
  typedef struct packed {
    logic             pass;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  val;
    logic [HUE_W-1:0] hue_base;
  } div_side_t;

endpackage

>>> rtl/phsv_in_if.sv
interface phsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

>>> rtl/phsv_out_if.sv
interface phsv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

>>> rtl/pixel_hsv_adjust_core.sv
// An accepted input word passes register A, the divider stages and registers B to G.
// Throughput: one pixel per clock while the output is not stalled; every stage holds
// its own valid bit, so bubbles close up while the output is stalled.
// The eight-stage divider for saturation and hue sets the depth of the pipeline.
// Reset clears all valid bits and sets the three shift registers to zero.
module pixel_hsv_adjust_core import phsv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  phsv_in_if.sink           pix_i,
  phsv_out_if.source        pix_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic signed [9:0] hue_shift_q;
  logic signed [8:0] sat_shift_q;
  logic signed [8:0] val_shift_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_shift_q <= '0;
      sat_shift_q <= '0;
      val_shift_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[3:2]))
        REG_HUE: hue_shift_q <= pwdata[9:0];
        REG_SAT: sat_shift_q <= pwdata[8:0];
        REG_VAL: val_shift_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[3:2]))
      REG_HUE: prdata = {{22{hue_shift_q[9]}}, hue_shift_q};
      REG_SAT: prdata = {{23{sat_shift_q[8]}}, sat_shift_q};
      REG_VAL: prdata = {{23{val_shift_q[8]}}, val_shift_q};
      default: prdata = '0;
    endcase
  end

  // Handshake chain, back to front.
  logic rdy_a, rdy_div, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g;
  logic a_vld_q, div_vld, b_vld_q, c_vld_q, d_vld_q, e_vld_q, f_vld_q, g_vld_q;

  assign rdy_g = !g_vld_q || pix_o.ready;
  assign rdy_f = !f_vld_q || rdy_g;
  assign rdy_e = !e_vld_q || rdy_f;
  assign rdy_d = !d_vld_q || rdy_e;
  assign rdy_c = !c_vld_q || rdy_d;
  assign rdy_b = !b_vld_q || rdy_c;
  assign rdy_a = !a_vld_q || rdy_div;
  assign pix_i.ready = rdy_a;

  // Stage A: max, min, delta and the division operands.
  logic [CH_W-1:0]  mx, mn, delta, hx;
  logic [HUE_W-1:0] hbase;
  max_chan_e        which;
  div_op_t          a_op_d, a_op_q;
  div_side_t        a_side_d, a_side_q;

  always_comb begin
    mx    = pix_i.red_in;
    mn    = pix_i.red_in;
    which = MAX_RED;
    if (pix_i.green_in > mx) begin
      mx    = pix_i.green_in;
      which = MAX_GREEN;
    end
    if (pix_i.blue_in > mx) begin
      mx    = pix_i.blue_in;
      which = MAX_BLUE;
    end
    if (pix_i.green_in < mn) mn = pix_i.green_in;
    if (pix_i.blue_in < mn) mn = pix_i.blue_in;
    delta = mx - mn;

    // The hue numerator term always lies in 0..delta.
    case (which)
      MAX_RED: begin
        if (pix_i.green_in >= pix_i.blue_in) begin
          hx    = pix_i.green_in - pix_i.blue_in;
          hbase = 9'd0;
        end else begin
          hx    = delta - (pix_i.blue_in - pix_i.green_in);
          hbase = 9'd300;
        end
      end
      MAX_GREEN: begin
        if (pix_i.blue_in > pix_i.red_in) begin
          hx    = pix_i.blue_in - pix_i.red_in;
          hbase = 9'd120;
        end else begin
          hx    = delta - (pix_i.red_in - pix_i.blue_in);
          hbase = 9'd60;
        end
      end
      default: begin
        if (pix_i.red_in > pix_i.green_in) begin
          hx    = pix_i.red_in - pix_i.green_in;
          hbase = 9'd240;
        end else begin
          hx    = delta - (pix_i.green_in - pix_i.red_in);
          hbase = 9'd180;
        end
      end
    endcase

    a_op_d.num_s = NUM_W'(delta) * S_SCALE + NUM_W'(mx);
    a_op_d.den_s = {mx, 1'b0};
    a_op_d.num_h = NUM_W'(hx) * H_SCALE + NUM_W'(delta);
    a_op_d.den_h = {delta, 1'b0};

    a_side_d.pass     = (pix_i.alpha_in == '0) ||
                        ((pix_i.red_in == pix_i.green_in) &&
                         (pix_i.green_in == pix_i.blue_in));
    a_side_d.red      = pix_i.red_in;
    a_side_d.green    = pix_i.green_in;
    a_side_d.blue     = pix_i.blue_in;
    a_side_d.alpha    = pix_i.alpha_in;
    a_side_d.val      = mx;
    a_side_d.hue_base = hbase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (rdy_a) begin
      a_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && pix_i.valid) begin
      a_op_q   <= a_op_d;
      a_side_q <= a_side_d;
    end
  end

  // Saturation and hue divisions.
  logic [QUO_W-1:0]       quo_s, quo_h;
  logic [$bits(div_side_t)-1:0] div_side_raw;
  div_side_t              div_side;

  phsv_divider #(
    .SIDE_W ($bits(div_side_t))
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_vld_q),
    .in_ready_o  (rdy_div),
    .in_op_i     (a_op_q),
    .in_side_i   (a_side_q),
    .out_valid_o (div_vld),
    .out_ready_i (rdy_b),
    .out_quo_s_o (quo_s),
    .out_quo_h_o (quo_h),
    .out_side_o  (div_side_raw)
  );

  assign div_side = div_side_t'(div_side_raw);

  // Stage B: add the shifts, wrap the hue, clamp saturation and value.
  logic signed [11:0] hsum;
  logic signed [10:0] ssum, vsum;
  logic [HUE_W-1:0]   b_hue_d, b_hue_q;
  logic [CH_W-1:0]    b_sat_d, b_sat_q, b_val_d, b_val_q;
  div_side_t          b_side_q;

  always_comb begin
    hsum = $signed({3'b000, div_side.hue_base}) + $signed({4'b0000, quo_h}) +
           $signed({{2{hue_shift_q[9]}}, hue_shift_q});
    if (hsum > 12'sd360) hsum = hsum - 12'sd360;
    if (hsum < 12'sd0) hsum = hsum + 12'sd360;
    if (hsum >= 12'sd360) hsum = hsum - 12'sd360;
    if (hsum < 12'sd0) hsum = hsum + 12'sd360;
    b_hue_d = hsum[HUE_W-1:0];

    ssum = $signed({3'b000, quo_s}) + $signed({{2{sat_shift_q[8]}}, sat_shift_q});
    if (ssum > 11'sd255) b_sat_d = CH_MAX;
    else if (ssum < 11'sd0) b_sat_d = '0;
    else b_sat_d = ssum[CH_W-1:0];

    vsum = $signed({3'b000, div_side.val}) + $signed({{2{val_shift_q[8]}}, val_shift_q});
    if (vsum > 11'sd255) b_val_d = CH_MAX;
    else if (vsum < 11'sd0) b_val_d = '0;
    else b_val_d = vsum[CH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (rdy_b) begin
      b_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && div_vld) begin
      b_hue_q  <= b_hue_d;
      b_sat_q  <= b_sat_d;
      b_val_q  <= b_val_d;
      b_side_q <= div_side;
    end
  end

  // Stage C: sextant and position inside it.
  sextant_e          c_sext_d, c_sext_q;
  logic [HUE_W-1:0]  c_base;
  logic [HUE_W-1:0]  c_fdiff;
  logic [FRAC_W-1:0] c_frac_q;
  logic [CH_W-1:0]   c_sat_q, c_val_q;
  div_side_t         c_side_q;

  always_comb begin
    if (b_hue_q >= 9'd300) begin
      c_sext_d = SEXT_5;
      c_base   = 9'd300;
    end else if (b_hue_q >= 9'd240) begin
      c_sext_d = SEXT_4;
      c_base   = 9'd240;
    end else if (b_hue_q >= 9'd180) begin
      c_sext_d = SEXT_3;
      c_base   = 9'd180;
    end else if (b_hue_q >= 9'd120) begin
      c_sext_d = SEXT_2;
      c_base   = 9'd120;
    end else if (b_hue_q >= HUE_SEXT) begin
      c_sext_d = SEXT_1;
      c_base   = HUE_SEXT;
    end else begin
      c_sext_d = SEXT_0;
      c_base   = 9'd0;
    end
    c_fdiff = b_hue_q - c_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (rdy_c) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && b_vld_q) begin
      c_sext_q <= c_sext_d;
      c_frac_q <= c_fdiff[FRAC_W-1:0];
      c_sat_q  <= b_sat_q;
      c_val_q  <= b_val_q;
      c_side_q <= b_side_q;
    end
  end

  // Stage D: saturation products.
  logic [13:0]       d_sf_q, d_st_q;
  logic [CH_W-1:0]   d_pinv_q, d_val_q;
  logic              d_szero_q;
  sextant_e          d_sext_q;
  div_side_t         d_side_q;
  logic [FRAC_W-1:0] c_rest;

  assign c_rest = FRAC_W'(HUE_SEXT) - c_frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (rdy_d) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_d && c_vld_q) begin
      d_sf_q    <= 14'(c_sat_q) * 14'(c_frac_q);
      d_st_q    <= 14'(c_sat_q) * 14'(c_rest);
      d_pinv_q  <= CH_MAX - c_sat_q;
      d_szero_q <= c_sat_q == '0;
      d_val_q   <= c_val_q;
      d_sext_q  <= c_sext_q;
      d_side_q  <= c_side_q;
    end
  end

  // Stage E: numerators of p, q and t.
  logic [NP_W-1:0] e_np_q;
  logic [NQ_W-1:0] e_nq_q, e_nt_q;
  logic [13:0]     d_qterm, d_tterm;
  logic [CH_W-1:0] e_val_q;
  logic            e_szero_q;
  sextant_e        e_sext_q;
  div_side_t       e_side_q;

  assign d_qterm = PQ_HALF - d_sf_q;
  assign d_tterm = PQ_HALF - d_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (rdy_e) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && d_vld_q) begin
      e_np_q    <= ((NP_W'(d_val_q) * NP_W'(d_pinv_q)) << 1) + NP_W'(CH_MAX);
      e_nq_q    <= ((NQ_W'(d_val_q) * NQ_W'(d_qterm)) << 1) + NQ_W'(PQ_HALF);
      e_nt_q    <= ((NQ_W'(d_val_q) * NQ_W'(d_tterm)) << 1) + NQ_W'(PQ_HALF);
      e_val_q   <= d_val_q;
      e_szero_q <= d_szero_q;
      e_sext_q  <= d_sext_q;
      e_side_q  <= d_side_q;
    end
  end

  // Stage F: constant divisions by reciprocal multiplication.
  logic [NP_W+RCP_P_W-1:0] prod_p;
  logic [NQ_W+RCP_Q_W-1:0] prod_q, prod_t;
  logic [CH_W-1:0]         f_p_q, f_q_q, f_t_q, f_val_q;
  logic                    f_szero_q;
  sextant_e                f_sext_q;
  div_side_t               f_side_q;

  assign prod_p = (NP_W+RCP_P_W)'(e_np_q) * (NP_W+RCP_P_W)'(RECIP_P);
  assign prod_q = (NQ_W+RCP_Q_W)'(e_nq_q) * (NQ_W+RCP_Q_W)'(RECIP_Q);
  assign prod_t = (NQ_W+RCP_Q_W)'(e_nt_q) * (NQ_W+RCP_Q_W)'(RECIP_Q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (rdy_f) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f && e_vld_q) begin
      f_p_q     <= prod_p[SHIFT_P +: CH_W];
      f_q_q     <= prod_q[SHIFT_Q +: CH_W];
      f_t_q     <= prod_t[SHIFT_Q +: CH_W];
      f_val_q   <= e_val_q;
      f_szero_q <= e_szero_q;
      f_sext_q  <= e_sext_q;
      f_side_q  <= e_side_q;
    end
  end

  // Stage G: pick the output channels.
  logic [CH_W-1:0] g_red_d, g_green_d, g_blue_d;
  logic [CH_W-1:0] g_red_q, g_green_q, g_blue_q, g_alpha_q;
  logic            g_grey_q;

  always_comb begin
    if (f_side_q.pass) begin
      g_red_d   = f_side_q.red;
      g_green_d = f_side_q.green;
      g_blue_d  = f_side_q.blue;
    end else if (f_szero_q) begin
      g_red_d   = f_val_q;
      g_green_d = f_val_q;
      g_blue_d  = f_val_q;
    end else begin
      case (f_sext_q)
        SEXT_0: begin
          g_red_d = f_val_q; g_green_d = f_t_q; g_blue_d = f_p_q;
        end
        SEXT_1: begin
          g_red_d = f_q_q; g_green_d = f_val_q; g_blue_d = f_p_q;
        end
        SEXT_2: begin
          g_red_d = f_p_q; g_green_d = f_val_q; g_blue_d = f_t_q;
        end
        SEXT_3: begin
          g_red_d = f_p_q; g_green_d = f_q_q; g_blue_d = f_val_q;
        end
        SEXT_4: begin
          g_red_d = f_t_q; g_green_d = f_p_q; g_blue_d = f_val_q;
        end
        default: begin
          g_red_d = f_val_q; g_green_d = f_p_q; g_blue_d = f_q_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (rdy_g) begin
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_g && f_vld_q) begin
      g_red_q   <= g_red_d;
      g_green_q <= g_green_d;
      g_blue_q  <= g_blue_d;
      g_alpha_q <= f_side_q.alpha;
      g_grey_q  <= !f_side_q.pass && f_szero_q;
    end
  end

  assign pix_o.valid     = g_vld_q;
  assign pix_o.red_out   = g_red_q;
  assign pix_o.green_out = g_green_q;
  assign pix_o.blue_out  = g_blue_q;
  assign pix_o.alpha_out = g_alpha_q;

  // A stalled output word is never dropped.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_vld_q && !pix_o.ready |=> g_vld_q)
    else $error("output word lost while stalled");

  // An empty input stage always takes a word.
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_vld_q |-> pix_i.ready)
    else $error("input refused with empty first stage");

  // The position inside a sextant of the wrapped hue stays below 60.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (c_frac_q < FRAC_W'(HUE_SEXT)))
    else $error("hue position outside its sextant");

  // Zero saturation gives a grey output word.
  a_grey_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_vld_q && g_grey_q |-> (g_red_q == g_green_q) && (g_green_q == g_blue_q))
    else $error("zero saturation did not give grey");

endmodule

>>> rtl/phsv_divider.sv
// Pipelined restoring divider, two lanes side by side, one quotient bit per stage.
// Each quotient must be known to fit in QUO_W bits.
module phsv_divider import phsv_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  div_op_t           in_op_i,
  input  logic [SIDE_W-1:0] in_side_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [QUO_W-1:0]  out_quo_s_o,
  output logic [QUO_W-1:0]  out_quo_h_o,
  output logic [SIDE_W-1:0] out_side_o
);

  typedef struct packed {
    logic [NUM_W-1:0] rem_s;
    logic [NUM_W-1:0] rem_h;
    logic [DEN_W-1:0] den_s;
    logic [DEN_W-1:0] den_h;
    logic [QUO_W-1:0] quo_s;
    logic [QUO_W-1:0] quo_h;
  } lane_t;

  lane_t             stage_q [QUO_W];
  logic [SIDE_W-1:0] side_q  [QUO_W];
  logic [QUO_W-1:0]  vld_q;
  logic [QUO_W:0]    rdy;

  assign rdy[QUO_W] = out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    lane_t             src;
    lane_t             nxt;
    logic              src_vld;
    logic [SIDE_W-1:0] src_side;
    logic [NUM_W-1:0]  dsh_s;
    logic [NUM_W-1:0]  dsh_h;
    logic              ge_s;
    logic              ge_h;

    // The first stage starts from the operands, the others from the stage before.
    if (k == 0) begin : g_first
      always_comb begin
        src.rem_s = in_op_i.num_s;
        src.rem_h = in_op_i.num_h;
        src.den_s = in_op_i.den_s;
        src.den_h = in_op_i.den_h;
        src.quo_s = '0;
        src.quo_h = '0;
      end
      assign src_vld  = in_valid_i;
      assign src_side = in_side_i;
    end else begin : g_next
      assign src      = stage_q[k-1];
      assign src_vld  = vld_q[k-1];
      assign src_side = side_q[k-1];
    end

    // Trial subtraction of the shifted divisor in both lanes.
    always_comb begin
      dsh_s     = NUM_W'(src.den_s) << SH;
      dsh_h     = NUM_W'(src.den_h) << SH;
      ge_s      = src.rem_s >= dsh_s;
      ge_h      = src.rem_h >= dsh_h;
      nxt       = src;
      nxt.rem_s = ge_s ? src.rem_s - dsh_s : src.rem_s;
      nxt.rem_h = ge_h ? src.rem_h - dsh_h : src.rem_h;
      nxt.quo_s = {src.quo_s[QUO_W-2:0], ge_s};
      nxt.quo_h = {src.quo_h[QUO_W-2:0], ge_h};
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_vld) begin
        stage_q[k] <= nxt;
        side_q[k]  <= src_side;
      end
    end
  end

  assign out_valid_o = vld_q[QUO_W-1];
  assign out_quo_s_o = stage_q[QUO_W-1].quo_s;
  assign out_quo_h_o = stage_q[QUO_W-1].quo_h;
  assign out_side_o  = side_q[QUO_W-1];

endmodule

>>> test/tb_pixel_hsv_adjust_core.sv
module tb_pixel_hsv_adjust_core;
  import phsv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_WORDS  = 1650;
  localparam int unsigned DRAIN_WAIT  = 40;

  // One pixel, as it goes in and as it comes out.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // One row of the directed table: the pixel and, where it is obvious, the result.
  typedef struct packed {
    pixel_t pix;
    logic   known;
    pixel_t result;
  } pixel_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  phsv_in_if  pix_in ();
  phsv_out_if pix_out ();

  pixel_hsv_adjust_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_in.sink),
    .pix_o   (pix_out.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the shift registers.
  int hue_shift_q;
  int sat_shift_q;
  int val_shift_q;

  pixel_t adjusted_q[$];
  int unsigned error_count;
  int unsigned cycle_count;
  logic stall_en;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Hard stop on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic int sext_field(input logic [31:0] raw, input int w);
    int x;
    x = int'(raw & ((32'd1 << w) - 1));
    if (raw[w-1]) x -= (1 << w);
    return x;
  endfunction

  // Integer HSV round trip with the current shifts.
  function automatic pixel_t adjust_pixel(input pixel_t p);
    pixel_t o;
    int r, g, b, mx, mn, dl, h, s, v, f, sx, pp, qq, tt;
    max_chan_e which;
    o = p;
    r = p.red;
    g = p.green;
    b = p.blue;
    if (p.alpha == 0 || (r == g && g == b)) return o;
    mx = r; mn = r; which = MAX_RED;
    if (g > mx) begin mx = g; which = MAX_GREEN; end
    if (b > mx) begin mx = b; which = MAX_BLUE; end
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    v = mx;
    s = (510 * dl + mx) / (2 * mx);
    case (which)
      MAX_RED: begin
        if (g >= b) h = (120 * (g - b) + dl) / (2 * dl);
        else h = (120 * (g - b + dl) + dl) / (2 * dl) + 300;
      end
      MAX_GREEN: begin
        if (b > r) h = 120 + (120 * (b - r) + dl) / (2 * dl);
        else h = 60 + (120 * (b - r + dl) + dl) / (2 * dl);
      end
      default: begin
        if (r > g) h = 240 + (120 * (r - g) + dl) / (2 * dl);
        else h = 180 + (120 * (r - g + dl) + dl) / (2 * dl);
      end
    endcase
    h += hue_shift_q;
    s += sat_shift_q;
    v += val_shift_q;
    if (h > 360) h -= 360;
    if (h < 0) h += 360;
    if (h >= 360) h -= 360;
    if (h < 0) h += 360;
    if (s > 255) s = 255;
    if (s < 0) s = 0;
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    r = v; g = v; b = v;
    if (s != 0) begin
      f = h % 60;
      sx = h / 60;
      pp = (2 * v * (255 - s) + 255) / 510;
      qq = (2 * v * (15300 - s * f) + 15300) / 30600;
      tt = (2 * v * (15300 - s * (60 - f)) + 15300) / 30600;
      case (sx)
        0: begin r = v;  g = tt; b = pp; end
        1: begin r = qq; g = v;  b = pp; end
        2: begin r = pp; g = v;  b = tt; end
        3: begin r = pp; g = qq; b = v;  end
        4: begin r = tt; g = pp; b = v;  end
        default: begin r = v; g = pp; b = qq; end
      endcase
    end
    o.red = r[7:0];
    o.green = g[7:0];
    o.blue = b[7:0];
    return o;
  endfunction

  // Write one shift register over the APB port and mirror it.
  task automatic write_shift(input cfg_reg_e idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HUE: hue_shift_q = sext_field(32'(value), 10);
      REG_SAT: sat_shift_q = sext_field(32'(value), 9);
      default: val_shift_q = sext_field(32'(value), 9);
    endcase
    // Leave the bus idle between transfers.
    @(posedge clk_i);
  endtask

  task automatic set_shifts(input int hs, input int ss, input int vs);
    write_shift(REG_HUE, hs);
    write_shift(REG_SAT, ss);
    write_shift(REG_VAL, vs);
  endtask

  // Present one word and hold it until the block takes it.
  task automatic send_pixel(input pixel_t p);
    pix_in.valid <= 1'b1;
    pix_in.red_in <= p.red;
    pix_in.green_in <= p.green;
    pix_in.blue_in <= p.blue;
    pix_in.alpha_in <= p.alpha;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    adjusted_q.push_back(adjust_pixel(p));
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      pix_in.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    pix_in.valid <= 1'b0;
    while (adjusted_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Random pixel, mostly colored and opaque, sometimes grey or transparent.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int k;
    p = pixel_t'($urandom);
    k = $urandom_range(0, 19);
    if (k == 0) p.alpha = 8'd0;
    else if (k == 1) begin p.green = p.red; p.blue = p.red; end
    else if (k == 2) p.green = p.red;
    else if (k == 3) p.blue = p.green;
    else if (k == 4) p.blue = p.red;
    return p;
  endfunction

  // Receiver: stalls in a pattern that changes phase now and then.
  always @(posedge clk_i) begin
    if (!stall_en) pix_out.ready <= 1'b1;
    else pix_out.ready <= ($urandom_range(0, 6) > 1);
  end

  // Compare every accepted output word with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (adjusted_q.size() == 0) begin
        $display("output word with nothing expected");
        error_count++;
      end else begin
        want = adjusted_q.pop_front();
        if (pix_out.red_out !== want.red) report_mismatch("red", pix_out.red_out, want.red);
        if (pix_out.green_out !== want.green)
          report_mismatch("green", pix_out.green_out, want.green);
        if (pix_out.blue_out !== want.blue)
          report_mismatch("blue", pix_out.blue_out, want.blue);
        if (pix_out.alpha_out !== want.alpha)
          report_mismatch("alpha", pix_out.alpha_out, want.alpha);
      end
    end
  end

  initial begin
    pixel_row_t rows[$];
    pixel_t want;
    int idx, burst;
    error_count = 0;
    cycle_count = 0;
    stall_en = 1'b0;
    hue_shift_q = 0;
    sat_shift_q = 0;
    val_shift_q = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.alpha_in = '0;
    pix_out.ready = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: transparent, grey, primaries, ties and extremes.
    rows.push_back({32'hFF00FF00, 1'b1, 32'hFF00FF00});
    rows.push_back({32'h000000FF, 1'b1, 32'h000000FF});
    rows.push_back({32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF});
    rows.push_back({32'h80808001, 1'b1, 32'h80808001});
    rows.push_back({32'hFF0000FF, 1'b1, 32'hFF0000FF});
    rows.push_back({32'h00FF00FF, 1'b1, 32'h00FF00FF});
    rows.push_back({32'h0000FF80, 1'b1, 32'h0000FF80});
    rows.push_back({32'hFFFF0010, 1'b0, 32'h0});
    rows.push_back({32'hFF00FF10, 1'b0, 32'h0});
    rows.push_back({32'h00FFFF10, 1'b0, 32'h0});
    rows.push_back({32'h010000FF, 1'b0, 32'h0});
    rows.push_back({32'hFFFEFD7F, 1'b0, 32'h0});
    rows.push_back({32'h12345678, 1'b0, 32'h0});
    rows.push_back({32'hA5C3F0FF, 1'b0, 32'h0});
    rows.push_back({32'h01020301, 1'b0, 32'h0});
    rows.push_back({32'hFE01FF55, 1'b0, 32'h0});
    for (idx = 0; idx < rows.size(); idx++) begin
      send_pixel(rows[idx].pix);
      want = adjusted_q[adjusted_q.size() - 1];
      if (rows[idx].known && want !== rows[idx].result)
        report_mismatch("table row", idx, 0);
    end
    wait_drained();

    // Shift extremes, including saturation dropping to zero and hue wrapping twice.
    set_shifts(360, 255, 255);
    for (idx = 0; idx < 6; idx++) send_pixel(rows[7 + idx].pix);
    wait_drained();
    set_shifts(-360, -255, -255);
    for (idx = 0; idx < 6; idx++) send_pixel(rows[7 + idx].pix);
    wait_drained();
    set_shifts(511, -100, 40);
    for (idx = 0; idx < 6; idx++) send_pixel(rows[7 + idx].pix);
    wait_drained();
    set_shifts(-512, 256, -256);
    for (idx = 0; idx < 6; idx++) send_pixel(rows[7 + idx].pix);
    wait_drained();

    // Random part in phases, each with its own shifts and its own stall pattern.
    stall_en = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      set_shifts($urandom_range(0, 1023), $urandom_range(0, 511), $urandom_range(0, 511));
      stall_en = (phase % 3 != 0);
      idx = 0;
      while (idx < RAND_WORDS / 8) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && idx < RAND_WORDS / 8) begin
          send_pixel(random_pixel());
          burst--;
          idx++;
        end
        if (phase != 2) idle_cycles($urandom_range(0, 4));
        // Let the whole pipeline empty in phase 4 if a burst ends at word 100.
        if (idx == 100 && phase == 4) wait_drained();
      end
      wait_drained();
    end

    if (adjusted_q.size() != 0) begin
      $display("%0d output words never arrived", adjusted_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/phsv_pkg.sv
rtl/phsv_in_if.sv
rtl/phsv_out_if.sv
rtl/phsv_divider.sv
rtl/pixel_hsv_adjust_core.sv
test/tb_pixel_hsv_adjust_core.sv
